// ===== hw/rtl/sida_pkg.sv =====
// ----------------------------------------------------------------------------
// sida_pkg
// Shared character type and ASCII codes for the decimal text converter.
// ----------------------------------------------------------------------------
package sida_pkg;

    typedef logic [7:0] t_char;

    localparam t_char CHAR_ZERO  = 8'h30;
    localparam t_char CHAR_MINUS = 8'h2D;
    localparam t_char CHAR_NINE  = 8'h39;

endpackage

// ===== hw/rtl/signed_int_to_decimal_ascii.sv =====
// ----------------------------------------------------------------------------
// signed_int_to_decimal_ascii
// Signed two's complement integer to decimal ASCII text, one character
// per output request.
// ----------------------------------------------------------------------------
// One request on the input gives its decimal text on the output, most
// significant character first: a leading '-' for negative values, no
// leading zeros, a single '0' for zero, and o_last high on the final
// character. The magnitude is converted by a bit-serial shift-and-add-3
// loop (one input bit per cycle), then leading zero digits are dropped
// at one digit per cycle, then one character is issued per cycle while
// the output is not stalled. Every cycle that the output stalls delays
// the end of the item, and so the next request. The block takes one
// item at a time: o_stall stays high from the accepting edge until the
// last character has been loaded into the output register. That register
// lets the next item be accepted while the last character still waits to
// be taken.
// ----------------------------------------------------------------------------
module signed_int_to_decimal_ascii #(
    parameter int VALUE_BITS = 32
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_stall,
    input  logic [VALUE_BITS-1:0] i_value,
    output logic                  o_valid,
    input  logic                  i_stall,
    output logic [7:0]            o_character,
    output logic                  o_last
);

    // Decimal digits of 2^(VALUE_BITS-1), the largest magnitude.
    localparam int NDIG = ((VALUE_BITS - 1) * 30103) / 100000 + 1;
    localparam int BCDW = 4 * NDIG;
    localparam int CW   = $clog2(VALUE_BITS);
    localparam int DW   = $clog2(NDIG + 1);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_CONV = 2'd1;
    localparam logic [1:0] S_SKIP = 2'd2;
    localparam logic [1:0] S_OUT  = 2'd3;

    logic [1:0]            r_state, n_state;
    logic [VALUE_BITS-1:0] r_mag, n_mag;
    logic [BCDW-1:0]       r_bcd, n_bcd;
    logic                  r_neg, n_neg;
    logic [CW-1:0]         r_cnt, n_cnt;
    logic [DW-1:0]         r_dcnt, n_dcnt;
    logic                  r_ovalid, n_ovalid;
    sida_pkg::t_char       r_char, n_char;
    logic                  r_last, n_last;

    logic [BCDW-1:0]       w_adj;
    logic [3:0]            w_top;
    logic                  w_load;

    assign w_top  = r_bcd[BCDW-1 -: 4];
    assign w_load = !r_ovalid || !i_stall;

    // Add 3 to every digit of 5 or more before the shift.
    always_comb begin
        for (int d = 0; d < NDIG; d++) begin
            w_adj[4*d +: 4] = (r_bcd[4*d +: 4] >= 4'd5) ? (r_bcd[4*d +: 4] + 4'd3)
                                                       : r_bcd[4*d +: 4];
        end
    end

    always_comb begin
        n_state  = r_state;
        n_mag    = r_mag;
        n_bcd    = r_bcd;
        n_neg    = r_neg;
        n_cnt    = r_cnt;
        n_dcnt   = r_dcnt;
        n_ovalid = r_ovalid;
        n_char   = r_char;
        n_last   = r_last;

        // Drop the output request once it has been taken.
        if (r_ovalid && !i_stall) begin
            n_ovalid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_neg   = i_value[VALUE_BITS-1];
                    n_mag   = i_value[VALUE_BITS-1] ? (VALUE_BITS'(0) - i_value) : i_value;
                    n_bcd   = '0;
                    n_cnt   = CW'(VALUE_BITS - 1);
                    n_state = S_CONV;
                end
            end
            S_CONV: begin
                n_bcd = {w_adj[BCDW-2:0], r_mag[VALUE_BITS-1]};
                n_mag = {r_mag[VALUE_BITS-2:0], 1'b0};
                n_cnt = r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    n_dcnt  = DW'(NDIG);
                    n_state = S_SKIP;
                end
            end
            S_SKIP: begin
                // Drop leading zero digits, keep at least one.
                if (w_top == 4'd0 && r_dcnt != DW'(1)) begin
                    n_bcd  = {r_bcd[BCDW-5:0], 4'd0};
                    n_dcnt = r_dcnt - 1'b1;
                end else begin
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (w_load) begin
                    n_ovalid = 1'b1;
                    if (r_neg) begin
                        n_char = sida_pkg::CHAR_MINUS;
                        n_last = 1'b0;
                        n_neg  = 1'b0;
                    end else begin
                        n_char = sida_pkg::CHAR_ZERO + {4'd0, w_top};
                        n_last = (r_dcnt == DW'(1));
                        n_bcd  = {r_bcd[BCDW-5:0], 4'd0};
                        n_dcnt = r_dcnt - 1'b1;
                        if (r_dcnt == DW'(1)) begin
                            n_state = S_IDLE;
                        end
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ovalid <= 1'b0;
            r_neg    <= 1'b0;
            r_cnt    <= '0;
            r_dcnt   <= '0;
        end else begin
            r_state  <= n_state;
            r_ovalid <= n_ovalid;
            r_neg    <= n_neg;
            r_cnt    <= n_cnt;
            r_dcnt   <= n_dcnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_mag  <= n_mag;
        r_bcd  <= n_bcd;
        r_char <= n_char;
        r_last <= n_last;
    end

    assign o_stall     = (r_state != S_IDLE);
    assign o_valid     = r_ovalid;
    assign o_character = r_char;
    assign o_last      = r_last;

endmodule

// ===== hw/rtl/sida_checker.sv =====
// ----------------------------------------------------------------------------
// sida_checker
// Port-level checks for the decimal text converter, bound to the top level.
// ----------------------------------------------------------------------------
module sida_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_valid,
    input logic       o_stall,
    input logic       o_valid,
    input logic       i_stall,
    input logic [7:0] o_character,
    input logic       o_last
);

    // A stalled output request holds.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_character) && $stable(o_last))
        else $error("output request changed while stalled");

    // Only digits and the minus sign appear.
    a_char_set: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> ((o_character >= sida_pkg::CHAR_ZERO &&
                      o_character <= sida_pkg::CHAR_NINE) ||
                     o_character == sida_pkg::CHAR_MINUS))
        else $error("character outside digit and minus set");

    // A minus sign is never marked as the last character.
    a_minus_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_character == sida_pkg::CHAR_MINUS |-> !o_last)
        else $error("minus sign marked as last");

    // Conversion occupies the block after an accepted request.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall |=> o_stall)
        else $error("second request accepted during conversion");

endmodule

bind signed_int_to_decimal_ascii sida_checker u_sida_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_valid     (i_valid),
    .o_stall     (o_stall),
    .o_valid     (o_valid),
    .i_stall     (i_stall),
    .o_character (o_character),
    .o_last      (o_last)
);
